// File: sv/hbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbp_pkg
// Shared types and constants for the Huffman code bit packer.
// ----------------------------------------------------------------------------
package hbp_pkg;

    // Item kinds carried on the input tuser
    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_ENCODE = 2'd1,
        ACT_FLUSH  = 2'd2
    } t_action;

    // Parameter defaults
    localparam int SYMBOL_COUNT_DEF = 256;
    localparam int MAX_CODE_LEN_DEF = 32;

    // Fixed field widths
    localparam int ACTION_W    = 2;
    localparam int SYMBOL_W    = 8;
    localparam int CODE_W      = 32;
    localparam int LEN_W       = 6;
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 48;
    localparam int MAX_BYTES   = 4;
    localparam int ENTRY_W     = CODE_W + LEN_W;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = BYTE_W + COUNT_W;

    // Saturation value of the running bit count
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

endpackage

// File: sv/hbp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/huffman_code_bit_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Huffman encoder back end: code table plus LSB-first byte packer.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser carries the item kind (load, encode, flush); tdata
//   carries symbol, code word and code length. A load writes the code table
//   entry of the symbol. An encode looks the symbol up and appends its code
//   bits, LSB first, to the pending byte; every byte that fills is sent.
//   A flush sends the pending byte (even if empty) with tlast and clears the
//   pending byte, bit position and bit count.
//   Output stream: tdata holds the byte and the saturating bit count; tlast
//   marks the final byte an item produces.
//   An item passes the table read register and then the packing register
//   (the output buffer) before its first output byte is valid.
//   Throughput: one input item per cycle while the output buffer is free;
//   an item that produces bytes (up to 4) holds the output buffer until
//   all are sent, so the byte-wide port sets the rate for full-byte items.
//   Reset clears the pipeline, the pending byte, bit position and count; the
//   code table holds no defined value until each entry is loaded.
//   When the receiver stalls, the byte on the output holds and input ready
//   drops once the packing stage has an item waiting for the output buffer.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer #(
    parameter int SYMBOL_COUNT = hbp_pkg::SYMBOL_COUNT_DEF,
    parameter int MAX_CODE_LEN = hbp_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input channel
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [7:0] symbol, [39:8] code_bits, [45:40] code_length, [47:46] zero
    input  logic [hbp_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // [1:0] action
    input  logic [hbp_pkg::ACTION_W-1:0]   i_s_tuser,
    // Output channel
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [7:0] out_byte, [55:8] total_bits
    output logic [hbp_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic                           o_m_tlast
);

    localparam int ADDR_W     = $clog2(SYMBOL_COUNT);
    localparam int CODE_LIMIT = (MAX_CODE_LEN < hbp_pkg::CODE_W) ? MAX_CODE_LEN
                                                                 : hbp_pkg::CODE_W;
    localparam int BYTE_W     = hbp_pkg::BYTE_W;
    localparam int COUNT_W    = hbp_pkg::COUNT_W;
    localparam int CODE_W     = hbp_pkg::CODE_W;
    localparam int LEN_W      = hbp_pkg::LEN_W;
    localparam int WIDE_W     = CODE_W + BYTE_W;
    localparam int OB_W       = hbp_pkg::MAX_BYTES * BYTE_W;

    // Input field split
    logic [hbp_pkg::SYMBOL_W-1:0] in_symbol;
    logic [CODE_W-1:0]            in_code;
    logic [LEN_W-1:0]             in_len;
    logic [LEN_W-1:0]             in_len_sat;
    logic                         in_sym_ok;
    hbp_pkg::t_action             in_action;
    logic                         in_accept;

    assign in_symbol = i_s_tdata[7:0];
    assign in_code   = i_s_tdata[39:8];
    assign in_len    = i_s_tdata[45:40];
    assign in_action = hbp_pkg::t_action'(i_s_tuser);
    assign in_sym_ok = ({1'b0, in_symbol} < 9'(SYMBOL_COUNT));
    assign in_len_sat = (in_len > LEN_W'(CODE_LIMIT)) ? LEN_W'(CODE_LIMIT) : in_len;
    assign in_accept  = i_s_tvalid && o_s_tready;

    // Code table: {length, code}
    logic                        tbl_we;
    logic                        tbl_re;
    logic [hbp_pkg::ENTRY_W-1:0] tbl_rdata;

    assign tbl_we = in_accept && (in_action == hbp_pkg::ACT_LOAD) && in_sym_ok;
    assign tbl_re = in_accept && (in_action == hbp_pkg::ACT_ENCODE);

    hbp_ram #(
        .WIDTH (hbp_pkg::ENTRY_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (in_symbol[ADDR_W-1:0]),
        .i_wdata ({in_len_sat, in_code}),
        .i_re    (tbl_re),
        .i_raddr (in_symbol[ADDR_W-1:0]),
        .o_rdata (tbl_rdata)
    );

    // Lookup stage registers
    logic             r_s1_valid;
    hbp_pkg::t_action r_s1_action;
    logic             r_s1_sym_ok;

    // Packer state
    logic [BYTE_W-1:0]  r_pend;
    logic [2:0]         r_pos;
    logic [COUNT_W-1:0] r_count;

    // Output buffer
    logic               r_ob_valid;
    logic [OB_W-1:0]    r_ob_data;
    logic [2:0]         r_ob_rem;
    logic [COUNT_W-1:0] r_ob_total;

    logic ob_free;
    logic needs_ob;
    logic s1_fire;

    assign ob_free  = !r_ob_valid || (i_m_tready && (r_ob_rem == 3'd1));
    assign needs_ob = (r_s1_action == hbp_pkg::ACT_ENCODE) ||
                      (r_s1_action == hbp_pkg::ACT_FLUSH);
    assign s1_fire  = r_s1_valid && (ob_free || !needs_ob);
    assign o_s_tready = !r_s1_valid || s1_fire;

    // Packing datapath
    logic [LEN_W-1:0]   enc_len;
    logic [CODE_W:0]    enc_mask;
    logic [CODE_W-1:0]  enc_code;
    logic [WIDE_W-1:0]  enc_wide;
    logic [6:0]         enc_sum;
    logic [2:0]         enc_nbytes;
    logic [BYTE_W-1:0]  enc_pend;
    logic [COUNT_W:0]   enc_csum;
    logic [COUNT_W-1:0] enc_count;

    always_comb begin
        enc_len  = r_s1_sym_ok ? tbl_rdata[CODE_W +: LEN_W] : '0;
        enc_mask = ((CODE_W+1)'(1) << enc_len) - (CODE_W+1)'(1);
        enc_code = tbl_rdata[CODE_W-1:0] & enc_mask[CODE_W-1:0];
        enc_wide = ({{BYTE_W{1'b0}}, enc_code} << r_pos) | {{CODE_W{1'b0}}, r_pend};
        enc_sum  = 7'(r_pos) + 7'(enc_len);
        enc_nbytes = enc_sum[5:3];
        case (enc_nbytes)
            3'd0:    enc_pend = enc_wide[7:0];
            3'd1:    enc_pend = enc_wide[15:8];
            3'd2:    enc_pend = enc_wide[23:16];
            3'd3:    enc_pend = enc_wide[31:24];
            3'd4:    enc_pend = enc_wide[39:32];
            default: enc_pend = '0;
        endcase
        enc_csum  = {1'b0, r_count} + (COUNT_W+1)'(enc_len);
        enc_count = enc_csum[COUNT_W] ? hbp_pkg::COUNT_MAX : enc_csum[COUNT_W-1:0];
    end

    // Lookup stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s1_action <= hbp_pkg::ACT_LOAD;
            r_s1_sym_ok <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid  <= 1'b1;
            r_s1_action <= in_action;
            r_s1_sym_ok <= in_sym_ok;
        end else if (s1_fire) begin
            r_s1_valid  <= 1'b0;
        end
    end

    // Packer state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= '0;
            r_pos   <= '0;
            r_count <= '0;
        end else if (s1_fire) begin
            case (r_s1_action)
                hbp_pkg::ACT_ENCODE: begin
                    r_pend  <= enc_pend;
                    r_pos   <= enc_sum[2:0];
                    r_count <= enc_count;
                end
                hbp_pkg::ACT_FLUSH: begin
                    r_pend  <= '0;
                    r_pos   <= '0;
                    r_count <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Output buffer: loaded by a flush or byte-filling encode, shifted per byte
    logic ob_load_enc;
    logic ob_load_flush;

    assign ob_load_enc   = s1_fire && (r_s1_action == hbp_pkg::ACT_ENCODE) &&
                           (enc_nbytes != 3'd0);
    assign ob_load_flush = s1_fire && (r_s1_action == hbp_pkg::ACT_FLUSH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_valid <= 1'b0;
            r_ob_rem   <= '0;
        end else if (ob_load_enc || ob_load_flush) begin
            r_ob_valid <= 1'b1;
            r_ob_rem   <= ob_load_enc ? enc_nbytes : 3'd1;
        end else if (r_ob_valid && i_m_tready) begin
            r_ob_valid <= (r_ob_rem != 3'd1);
            r_ob_rem   <= r_ob_rem - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ob_load_enc) begin
            r_ob_data  <= enc_wide[OB_W-1:0];
            r_ob_total <= enc_count;
        end else if (ob_load_flush) begin
            r_ob_data  <= {{(OB_W-BYTE_W){1'b0}}, r_pend};
            r_ob_total <= r_count;
        end else if (r_ob_valid && i_m_tready) begin
            r_ob_data  <= {{BYTE_W{1'b0}}, r_ob_data[OB_W-1:BYTE_W]};
        end
    end

    // Output port
    assign o_m_tvalid = r_ob_valid;
    assign o_m_tdata  = {r_ob_total, r_ob_data[BYTE_W-1:0]};
    assign o_m_tlast  = (r_ob_rem == 3'd1);

endmodule

// File: sv/hbp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbp_checker
// Port-level checks for the Huffman code bit packer, bound to the top level.
// ----------------------------------------------------------------------------
module hbp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_s_tready,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [hbp_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input logic                           o_m_tlast
);

    localparam int BYTE_W = hbp_pkg::BYTE_W;

    // Nothing is offered right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_m_tvalid)
        else $error("output valid right after reset");

    // A stalled output transaction holds its byte, count and last flag
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output changed while stalled");

    // Bytes of one item follow back to back and share the bit count
    a_burst_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(o_m_tvalid && i_m_tready && !o_m_tlast) |->
            o_m_tvalid &&
            (o_m_tdata[hbp_pkg::OUT_DATA_W-1:BYTE_W] ==
             $past(o_m_tdata[hbp_pkg::OUT_DATA_W-1:BYTE_W])))
        else $error("burst broken or bit count changed inside a burst");

    // Input back-pressure only comes from a waiting output byte
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with empty output");

endmodule

bind huffman_code_bit_packer hbp_checker u_hbp_checker (.*);
